@@ src/alsid_pkg.sv @@
package alsid_pkg;

  // fixed widths of the result fields
  localparam int unsigned PosW  = 7;
  localparam int unsigned FillW = 8;

  // operation codes carried by mode_i
  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_SEARCH = 2'd1,
    MODE_DELETE = 2'd2
  } mode_e;

  // source of the reported position
  typedef enum logic [1:0] {
    POS_ZERO = 2'd0,
    POS_PIPE = 2'd1,
    POS_HIT  = 2'd2
  } pos_sel_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_DISPATCH = 2'd1,
    ST_SCAN     = 2'd2,
    ST_SHIFT    = 2'd3
  } state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic     load;      // latch request, rewind the walk pointer
    logic     scan;      // advance the compare walk by one entry
    logic     shift_go;  // capture hit index, aim the walk just past it
    logic     shift;     // advance the move-down walk by one entry
    logic     insert;    // append value at the end
    logic     del_dec;   // drop one from the count, clear entry zero if emptied
    logic     emit;      // present a result beat
    logic     ok;        // ok flag of that beat
    pos_sel_e pos_sel;   // position of that beat
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic [1:0] mode;
    logic       full;
    logic       match;      // entry in compare stage equals the value
    logic       walk_done;  // pointer at the count and nothing in flight
  } status_t;

endpackage

@@ src/alsid_ctrl.sv @@
module alsid_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  alsid_pkg::status_t st_i,
  output alsid_pkg::cmd_t    cmd_o,
  output logic              busy_o
);
  import alsid_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.pos_sel = POS_ZERO;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (mode_e'(st_i.mode)) inside
          MODE_INSERT: begin
            cmd_o.emit = 1'b1;
            if (!st_i.full) begin
              cmd_o.insert = 1'b1;
              cmd_o.ok     = 1'b1;
            end
            state_d = ST_IDLE;
          end
          MODE_SEARCH, MODE_DELETE: begin
            cmd_o.scan = 1'b1;
            state_d    = ST_SCAN;
          end
          default: begin
            cmd_o.emit = 1'b1;
            state_d    = ST_IDLE;
          end
        endcase
      end
      ST_SCAN: begin
        if (st_i.match) begin
          if (mode_e'(st_i.mode) == MODE_DELETE) begin
            cmd_o.shift_go = 1'b1;
            state_d        = ST_SHIFT;
          end else begin
            cmd_o.emit    = 1'b1;
            cmd_o.ok      = 1'b1;
            cmd_o.pos_sel = POS_PIPE;
            state_d       = ST_IDLE;
          end
        end else if (st_i.walk_done) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      ST_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (st_i.walk_done) begin
          cmd_o.del_dec = 1'b1;
          cmd_o.emit    = 1'b1;
          cmd_o.ok      = 1'b1;
          cmd_o.pos_sel = POS_HIT;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  // no work is commanded while idle
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !(cmd_o.scan || cmd_o.shift || cmd_o.emit || cmd_o.insert))
    else $error("command issued while idle");

endmodule

@@ src/alsid_dpath.sv @@
module alsid_dpath #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  alsid_pkg::cmd_t               cmd_i,
  output alsid_pkg::status_t            st_o,
  input  logic [1:0]                    mode_i,
  input  logic signed [31:0]            value_i,
  output logic                          done_o,
  output logic                          ok_o,
  output logic [alsid_pkg::PosW-1:0]    position_o,
  output logic [alsid_pkg::FillW-1:0]   fill_count_o
);
  import alsid_pkg::*;

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic signed [31:0] mem [CAPACITY];
  logic signed [31:0] rdata_q;

  logic [1:0]         mode_q;
  logic signed [31:0] value_q;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      ptr_q, ptr_d;
  logic               pipe_vld_q, pipe_vld_d;
  logic [IW-1:0]      pipe_idx_q, pipe_idx_d;
  logic [IW-1:0]      hit_q;
  logic               done_q, ok_q;
  logic [IW-1:0]      pos_q, pos_d;

  logic               we;
  logic [IW-1:0]      waddr;
  logic signed [31:0] wdata;
  logic [CW-1:0]      ptr_dec;
  logic               ptr_live;

  // request latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= mode_i;
      value_q <= value_i;
    end
    if (cmd_i.shift_go) begin
      hit_q <= pipe_idx_q;
    end
  end

  // walk pointer and compare/move pipeline
  assign ptr_live = (ptr_q < count_q);
  assign ptr_dec  = ptr_q - CW'(1);

  always_comb begin
    ptr_d      = ptr_q;
    pipe_vld_d = pipe_vld_q;
    pipe_idx_d = pipe_idx_q;
    if (cmd_i.load) begin
      ptr_d      = '0;
      pipe_vld_d = 1'b0;
    end else if (cmd_i.shift_go) begin
      ptr_d      = CW'(pipe_idx_q) + CW'(1);
      pipe_vld_d = 1'b0;
    end else if (cmd_i.scan || cmd_i.shift) begin
      pipe_vld_d = ptr_live;
      if (ptr_live) begin
        ptr_d      = ptr_q + CW'(1);
        pipe_idx_d = cmd_i.shift ? ptr_dec[IW-1:0] : ptr_q[IW-1:0];
      end
    end
  end

  // count and result update
  always_comb begin
    count_d = count_q;
    if (cmd_i.insert) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.del_dec) begin
      count_d = count_q - CW'(1);
    end
    case (cmd_i.pos_sel)
      POS_PIPE: pos_d = pipe_idx_q;
      POS_HIT:  pos_d = hit_q;
      default:  pos_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      ptr_q      <= '0;
      pipe_vld_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      count_q    <= count_d;
      ptr_q      <= ptr_d;
      pipe_vld_q <= pipe_vld_d;
      done_q     <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_idx_q <= pipe_idx_d;
    if (cmd_i.emit) begin
      ok_q  <= cmd_i.ok;
      pos_q <= pos_d;
    end
  end

  // store write port: move-down, append, clear of entry zero
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    if (cmd_i.shift && pipe_vld_q) begin
      we    = 1'b1;
      waddr = pipe_idx_q;
      wdata = rdata_q;
    end else if (cmd_i.insert) begin
      we    = 1'b1;
      waddr = count_q[IW-1:0];
      wdata = value_q;
    end else if (cmd_i.del_dec && (count_q == CW'(1))) begin
      we    = 1'b1;
      waddr = '0;
      wdata = '0;
    end
  end

  // element store
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[ptr_q[IW-1:0]];
  end

  // status to the controller
  assign st_o.mode      = mode_q;
  assign st_o.full      = (count_q == CW'(CAPACITY));
  assign st_o.match     = pipe_vld_q && (rdata_q == value_q);
  assign st_o.walk_done = !pipe_vld_q && !ptr_live;

  // result ports
  logic [CW+FillW-1:0] fill_ext;
  logic [IW+PosW-1:0]  pos_ext;

  assign fill_ext     = (CW+FillW)'(count_q);
  assign pos_ext      = (IW+PosW)'(pos_q);
  assign done_o       = done_q;
  assign ok_o         = ok_q;
  assign position_o   = pos_ext[PosW-1:0];
  assign fill_count_o = fill_ext[FillW-1:0];

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("fill count above capacity");

  a_move_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.shift && pipe_vld_q) |-> ((CW'(pipe_idx_q) + CW'(1)) < count_q))
    else $error("move-down write outside the list");

  a_fail_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !ok_q) |-> (count_q == $past(count_q)))
    else $error("failed request changed the count");

endmodule

@@ src/array_list_insert_search_delete.sv @@
// channel   dir  ports                                   beat taken when
// request   in   start_i, mode_i, value_i                start_i && !busy_o
// result    out  done_o, ok_o, position_o, fill_count_o  done_o (one cycle)
//
// insert and unused modes: the result is issued from the dispatch state, with no walk
// search: the compare walk runs up from entry zero and ends at the first hit or the end
// delete: the compare walk finds the hit, then the move-down walk closes the gap;
// the walks read one store entry per cycle through the single read port, first
// for the compare walk and then for the move-down walk
// reset clears the count and control state only; the store needs no clearing
// results cannot be held off; busy_o falls in the cycle the result is shown
module array_list_insert_search_delete #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    mode_i,
  input  logic signed [31:0]            value_i,
  output logic                          done_o,
  output logic                          ok_o,
  output logic [alsid_pkg::PosW-1:0]    position_o,
  output logic [alsid_pkg::FillW-1:0]   fill_count_o
);
  import alsid_pkg::*;

  cmd_t    cmd;
  status_t st;

  // sequencer
  alsid_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .st_i    (st),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // store, walk pointer and result registers
  alsid_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .st_o         (st),
    .mode_i       (mode_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .ok_o         (ok_o),
    .position_o   (position_o),
    .fill_count_o (fill_count_o)
  );

  // every result beat closes a request that was in progress
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result beat without a request in progress");

endmodule

@@ dv/list_tracker_pkg.sv @@
`timescale 1ns / 1ps
package list_tracker_pkg;
  import alsid_pkg::*;

  localparam int unsigned ListDepth   = 128;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;

  // one expected result beat
  typedef struct packed {
    logic             ok;
    logic [PosW-1:0]  position;
    logic [FillW-1:0] fill;
  } list_reply_t;

  class list_tracker;
    logic signed [31:0] entries [ListDepth];
    int                 fill_level;
    list_reply_t        pending_replies [$];
    int unsigned        error_count;

    function new();
      fill_level  = 0;
      error_count = 0;
    endfunction

    // mirror one request beat into the list and queue its reply
    function void apply_request(logic [1:0] mode, logic signed [31:0] value);
      int          hit;
      list_reply_t reply;
      hit = -1;
      // lowest matching index among the live entries
      for (int i = fill_level - 1; i >= 0; i--) begin
        if (entries[i] == value) hit = i;
      end
      reply.ok       = 1'b0;
      reply.position = '0;
      case (mode)
        MODE_INSERT: begin
          // refused with ok low once full
          if (fill_level < ListDepth) begin
            entries[fill_level] = value;
            fill_level++;
            reply.ok = 1'b1;
          end
        end
        MODE_SEARCH: begin
          if (hit >= 0) begin
            reply.ok       = 1'b1;
            reply.position = hit[PosW-1:0];
          end
        end
        MODE_DELETE: begin
          // close the gap, clear entry zero once emptied
          if (hit >= 0) begin
            reply.ok       = 1'b1;
            reply.position = hit[PosW-1:0];
            for (int i = hit; i + 1 < fill_level; i++) entries[i] = entries[i + 1];
            fill_level--;
            if (fill_level == 0) entries[0] = '0;
          end
        end
        default: ;
      endcase
      reply.fill = fill_level[FillW-1:0];
      pending_replies.push_back(reply);
    endfunction

    // compare one result beat with the oldest queued reply
    function void check_reply(logic ok, logic [PosW-1:0] position, logic [FillW-1:0] fill);
      list_reply_t want;
      if (pending_replies.size() == 0) begin
        $error("result beat with no request outstanding");
        error_count++;
        return;
      end
      want = pending_replies.pop_front();
      if (ok !== want.ok) begin
        $error("ok: expected %0d, got %0d", want.ok, ok);
        error_count++;
      end
      if (position !== want.position) begin
        $error("position: expected %0d, got %0d", want.position, position);
        error_count++;
      end
      if (fill !== want.fill) begin
        $error("fill_count: expected %0d, got %0d", want.fill, fill);
        error_count++;
      end
    endfunction

    // a value currently held in the list, random when empty
    function logic signed [31:0] stored_value();
      if (fill_level == 0) return $urandom;
      return entries[$urandom_range(0, fill_level - 1)];
    endfunction
  endclass

endpackage

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import alsid_pkg::*;
  import list_tracker_pkg::*;

  localparam int unsigned CycleLimit  = 800_000;
  localparam int unsigned DrainCycles = 2 * ListDepth + 16;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [1:0]         mode_i;
  logic signed [31:0] value_i;
  logic               done_o;
  logic               ok_o;
  logic [PosW-1:0]    position_o;
  logic [FillW-1:0]   fill_count_o;

  int unsigned cycle_count = 0;
  list_tracker tracker;

  array_list_insert_search_delete #(
    .CAPACITY(ListDepth)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .mode_i      (mode_i),
    .value_i     (value_i),
    .done_o      (done_o),
    .ok_o        (ok_o),
    .position_o  (position_o),
    .fill_count_o(fill_count_o)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) tracker.check_reply(ok_o, position_o, fill_count_o);
  end

  // random idle cycles ahead of a beat, each ready cycle idles about 26 in 100
  function automatic int unsigned idle_gap(bit quiet);
    int unsigned n;
    n = 0;
    if (quiet) return 0;
    while ($urandom_range(0, 99) < 26) n++;
    return n;
  endfunction

  // present one request and hold it until taken
  task automatic send_beat(input logic [1:0] mode, input logic signed [31:0] value,
                           input int unsigned gap);
    // idle cycles only count once the block can take a beat
    if (gap != 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      while (busy_o) @(negedge clk_i);
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    mode_i  <= mode;
    value_i <= value;
    do @(posedge clk_i); while (busy_o);
    tracker.apply_request(mode, value);
  endtask

  initial begin
    int unsigned        ins_w;
    int unsigned        srch_w;
    int unsigned        del_w;
    int unsigned        roll;
    logic [1:0]         mode;
    logic signed [31:0] value;

    tracker = new();
    rst_ni  = 1'b0;
    start_i = 1'b0;
    mode_i  = MODE_INSERT;
    value_i = '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty list, unused mode
    send_beat(MODE_SEARCH, 32'sd0, idle_gap(0));
    send_beat(MODE_DELETE, 32'sd5, idle_gap(0));
    send_beat(MODE_UNUSED, 32'sh7FFF_FFFF, idle_gap(0));
    // extremes and a duplicate
    send_beat(MODE_INSERT, 32'sh8000_0000, idle_gap(0));
    send_beat(MODE_INSERT, 32'sh7FFF_FFFF, idle_gap(0));
    send_beat(MODE_INSERT, 32'sd0, idle_gap(0));
    send_beat(MODE_INSERT, 32'shFFFF_FFFF, idle_gap(0));
    send_beat(MODE_INSERT, 32'sh7FFF_FFFF, idle_gap(0));
    send_beat(MODE_INSERT, 32'sd1, idle_gap(0));
    // lookups: lowest duplicate, first, last, missing
    send_beat(MODE_SEARCH, 32'sh7FFF_FFFF, idle_gap(0));
    send_beat(MODE_SEARCH, 32'sh8000_0000, idle_gap(0));
    send_beat(MODE_SEARCH, 32'sd1, idle_gap(0));
    send_beat(MODE_SEARCH, 32'sd12345, idle_gap(0));
    send_beat(MODE_UNUSED, 32'shFFFF_FFFF, idle_gap(0));
    // deletes down to an empty list
    send_beat(MODE_DELETE, 32'sh7FFF_FFFF, idle_gap(0));
    send_beat(MODE_SEARCH, 32'sh7FFF_FFFF, idle_gap(0));
    send_beat(MODE_DELETE, 32'sd1, idle_gap(0));
    send_beat(MODE_DELETE, 32'sh8000_0000, idle_gap(0));
    send_beat(MODE_DELETE, 32'sd777, idle_gap(0));
    send_beat(MODE_DELETE, 32'sd0, idle_gap(0));
    send_beat(MODE_DELETE, 32'shFFFF_FFFF, idle_gap(0));
    send_beat(MODE_DELETE, 32'sh7FFF_FFFF, idle_gap(0));
    send_beat(MODE_SEARCH, 32'sd0, idle_gap(0));
    send_beat(MODE_INSERT, 32'sd0, idle_gap(0));
    send_beat(MODE_SEARCH, 32'sd0, idle_gap(0));

    // random: fill past full, churn at full, drain, then mixed
    for (int n = 0; n < 540; n++) begin
      if (n < 160) begin
        ins_w = 90; srch_w = 5; del_w = 4;
      end else if (n < 260) begin
        ins_w = 25; srch_w = 45; del_w = 25;
      end else if (n < 440) begin
        ins_w = 3; srch_w = 10; del_w = 85;
      end else begin
        ins_w = 40; srch_w = 30; del_w = 27;
      end
      roll = $urandom_range(0, 99);
      if (roll < ins_w) mode = MODE_INSERT;
      else if (roll < ins_w + srch_w) mode = MODE_SEARCH;
      else if (roll < ins_w + srch_w + del_w) mode = MODE_DELETE;
      else mode = MODE_UNUSED;
      // small values make duplicates, stored values make hits
      roll = $urandom_range(0, 99);
      if (mode == MODE_INSERT) begin
        if (roll < 40) value = $urandom_range(0, 15) - 8;
        else if (roll < 80) value = $urandom;
        else value = tracker.stored_value();
      end else begin
        if (roll < 88) value = tracker.stored_value();
        else if (roll < 94) value = $urandom_range(0, 15) - 8;
        else value = $urandom;
      end
      send_beat(mode, value, idle_gap(n >= 200 && n < 320));
    end
    @(negedge clk_i);
    start_i <= 1'b0;

    // let outstanding results arrive, then watch for strays
    while (tracker.pending_replies.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (tracker.error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
